// File: rtl/core/tfc_pkg.sv
package tfc_pkg;

	// Configuration port
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 60;
	localparam int NUM_PLANE_REGS = 6;
	localparam int CNT_W          = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = CFG_IDX_W'(NUM_PLANE_REGS);

	localparam logic [CNT_W-1:0] PLANE_COUNT_RST = CNT_W'(6);

	// Plane word fields
	localparam int NRM_W   = 12;
	localparam int DIST_W  = 24;
	// d is Q16.8, products are Q.18: align d by the normal's fraction bits
	localparam int D_ALIGN = 10;

	localparam int NUM_VERTS = 3;
	localparam int NUM_AXES  = 3;

	// Queue between classifier and mesh tracker
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [NRM_W-1:0]  nx;
		logic [NRM_W-1:0]  ny;
		logic [NRM_W-1:0]  nz;
		logic [DIST_W-1:0] d;
	} plane_t;

	// One classified triangle
	typedef struct packed {
		logic culled;
		logic last;
	} item_t;

	// Queue status seen by the front part
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: rtl/core/triangle_frustum_cull_core.sv
// Path: an accepted triangle passes two classifier stages, one queue slot and one
// output register before out_valid rises.
// Throughput: one triangle per cycle while the queue has room; the classifier runs 9 x MAX_PLANES
// multipliers in parallel lanes and a 4-entry queue decouples it from the output.
// Reset: planes clear to zero, plane_count to 6, the mesh flag to 1, the queue empty.
module triangle_frustum_cull_core import tfc_pkg::*; #(
	parameter int MAX_PLANES = 6,
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] v0_x,
	input  logic signed [COORD_BITS-1:0] v0_y,
	input  logic signed [COORD_BITS-1:0] v0_z,
	input  logic signed [COORD_BITS-1:0] v1_x,
	input  logic signed [COORD_BITS-1:0] v1_y,
	input  logic signed [COORD_BITS-1:0] v1_z,
	input  logic signed [COORD_BITS-1:0] v2_x,
	input  logic signed [COORD_BITS-1:0] v2_y,
	input  logic signed [COORD_BITS-1:0] v2_z,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         triangle_culled,
	output logic                         mesh_outside,
	output logic                         end_of_mesh
);

	logic signed [COORD_BITS-1:0] coord [NUM_VERTS][NUM_AXES];
	logic      q_push, q_pop;
	item_t     push_item, pop_item;
	q_status_t q_status;

	// Gather the vertices
	always_comb begin
		coord[0][0] = v0_x; coord[0][1] = v0_y; coord[0][2] = v0_z;
		coord[1][0] = v1_x; coord[1][1] = v1_y; coord[1][2] = v1_z;
		coord[2][0] = v2_x; coord[2][1] = v2_y; coord[2][2] = v2_z;
	end

	tfc_front #(
		.MAX_PLANES(MAX_PLANES),
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.coord     (coord),
		.last      (last),
		.q_status  (q_status),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	tfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	tfc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (!q_status.empty),
		.q_item          (pop_item),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.triangle_culled (triangle_culled),
		.mesh_outside    (mesh_outside),
		.end_of_mesh     (end_of_mesh)
	);

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_status.full) else $error("input stalled with queue room");
	a_outside_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mesh_outside) |-> end_of_mesh) else $error("mesh outside before last");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full) else $error("classified triangle dropped");
`endif

endmodule

// File: rtl/core/tfc_front.sv
module tfc_front import tfc_pkg::*; #(
	parameter int MAX_PLANES = 6,
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] coord [NUM_VERTS][NUM_AXES],
	input  logic                         last,
	input  q_status_t                    q_status,
	output logic                         q_push,
	output item_t                        q_item
);

	localparam int PROD_W = COORD_BITS + NRM_W;
	localparam int ALN_W  = DIST_W + D_ALIGN;
	localparam int SUM_W  = ((PROD_W > ALN_W) ? PROD_W : ALN_W) + 2;

	plane_t            plane_q [MAX_PLANES];
	logic [CNT_W-1:0]  plane_count_q;

	logic signed [NRM_W-1:0]  nrm [MAX_PLANES][NUM_AXES];
	logic signed [PROD_W-1:0] prod_s1 [MAX_PLANES][NUM_VERTS][NUM_AXES];
	logic signed [SUM_W-1:0]  dist_c [MAX_PLANES][NUM_VERTS];
	logic [NUM_VERTS-1:0]     behind_s2 [MAX_PLANES];
	logic                     valid_s1, valid_s2;
	logic                     last_s1, last_s2;
	logic                     advance;
	logic [CNT_W-1:0]         n_sat;
	logic                     culled_c;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < MAX_PLANES; p++) plane_q[p] <= '0;
			plane_count_q <= PLANE_COUNT_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_PLANE_COUNT) begin
				plane_count_q <= cfg_data[CNT_W-1:0];
			end
			for (int p = 0; p < MAX_PLANES; p++) begin
				if (cfg_index == CFG_IDX_W'(p)) plane_q[p] <= plane_t'(cfg_data);
			end
		end
	end

	// Stall the whole front when the last stage cannot hand over
	assign advance  = !(valid_s2 && q_status.full);
	assign in_ready = advance;

	always_comb begin
		for (int p = 0; p < MAX_PLANES; p++) begin
			nrm[p][0] = $signed(plane_q[p].nx);
			nrm[p][1] = $signed(plane_q[p].ny);
			nrm[p][2] = $signed(plane_q[p].nz);
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: one product per plane, vertex and axis
	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1 <= last;
			for (int p = 0; p < MAX_PLANES; p++) begin
				for (int v = 0; v < NUM_VERTS; v++) begin
					for (int a = 0; a < NUM_AXES; a++) begin
						prod_s1[p][v][a] <= PROD_W'(nrm[p][a]) * PROD_W'(coord[v][a]);
					end
				end
			end
		end
	end

	// Stage 2: exact distance, keep only its sign
	always_comb begin
		for (int p = 0; p < MAX_PLANES; p++) begin
			for (int v = 0; v < NUM_VERTS; v++) begin
				dist_c[p][v] = SUM_W'(prod_s1[p][v][0]) + SUM_W'(prod_s1[p][v][1])
					+ SUM_W'(prod_s1[p][v][2])
					+ (SUM_W'($signed(plane_q[p].d)) <<< D_ALIGN);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s2 <= last_s1;
			for (int p = 0; p < MAX_PLANES; p++) begin
				for (int v = 0; v < NUM_VERTS; v++) begin
					behind_s2[p][v] <= dist_c[p][v][SUM_W-1];
				end
			end
		end
	end

	// Classify: culled when all vertices sit behind one enabled plane
	always_comb begin
		n_sat = (plane_count_q > CNT_W'(MAX_PLANES)) ? CNT_W'(MAX_PLANES) : plane_count_q;
		culled_c = 1'b0;
		for (int p = 0; p < MAX_PLANES; p++) begin
			if ((CNT_W'(p) < n_sat) && (&behind_s2[p])) culled_c = 1'b1;
		end
	end

	assign q_push        = valid_s2 && !q_status.full;
	assign q_item.culled = culled_c;
	assign q_item.last   = last_s2;

endmodule

// File: rtl/core/tfc_queue.sv
module tfc_queue import tfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     push_item,
	input  logic      pop,
	output item_t     pop_item,
	output q_status_t status
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	assign pop_item     = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.empty |-> !pop) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// File: rtl/core/tfc_back.sv
module tfc_back import tfc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	output logic  out_valid,
	input  logic  out_ready,
	output logic  triangle_culled,
	output logic  mesh_outside,
	output logic  end_of_mesh
);

	logic all_culled_q;
	logic out_valid_q;
	logic culled_q, outside_q, last_q;
	logic acc;

	// Take the next transaction when the output register is free or draining
	assign q_pop = q_valid && (!out_valid_q || out_ready);
	assign acc   = all_culled_q && q_item.culled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_culled_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q  <= 1'b1;
				all_culled_q <= q_item.last ? 1'b1 : acc;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			culled_q  <= q_item.culled;
			outside_q <= q_item.last && acc;
			last_q    <= q_item.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign triangle_culled = culled_q;
	assign mesh_outside    = outside_q;
	assign end_of_mesh     = last_q;

`ifndef SYNTHESIS
	a_mesh_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.last) |=> all_culled_q) else $error("mesh flag not restarted");
	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_item.last && !q_item.culled) |=> !all_culled_q)
		else $error("uncovered triangle not recorded");
	a_outside_implies: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && outside_q) |-> (last_q && culled_q))
		else $error("mesh outside without culled last triangle");
`endif

endmodule

// File: verif/tb_triangle_frustum_cull_core.sv
module tb_triangle_frustum_cull_core;
	import tfc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PLANES   = 6;
	localparam int COORD_W      = 24;
	localparam int ITEMS_PER_RUN = 170;
	localparam int RANDOM_RUNS  = 12;
	localparam int STALL_CYCLES = 300;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE       = 8;
	localparam int TIMEOUT_NS   = 3_000_000;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_0 = '0;
	// index past the last register: writes must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_NONE    = '1;

	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef logic [COORD_W-1:0] coord_t;

	// coords[3*vertex + axis], axis order x, y, z
	typedef struct packed {
		logic [8:0][COORD_W-1:0] coords;
		logic                    last;
	} triangle_t;

	typedef struct packed {
		logic culled;
		logic outside;
		logic eom;
	} verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  triangle_culled;
	logic                  mesh_outside;
	logic                  end_of_mesh;
	triangle_t             cur_face = '0;

	// culling state mirrored from the block
	logic [CFG_DATA_W-1:0] pred_planes [NUM_PLANE_REGS];
	logic [CNT_W-1:0]      pred_plane_count;
	logic                  pred_all_culled;

	triangle_t pending_faces [$];
	verdict_t  expected_verdicts [$];

	int  send_idle_pct = 17;
	int  recv_idle_pct = 67;
	int  mismatches = 0;
	bit  stall_wanted = 1'b0;
	logic rx_hold = 1'b0;

	triangle_frustum_cull_core #(
		.MAX_PLANES(MAX_PLANES),
		.COORD_BITS(COORD_W)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.v0_x           (cur_face.coords[0]),
		.v0_y           (cur_face.coords[1]),
		.v0_z           (cur_face.coords[2]),
		.v1_x           (cur_face.coords[3]),
		.v1_y           (cur_face.coords[4]),
		.v1_z           (cur_face.coords[5]),
		.v2_x           (cur_face.coords[6]),
		.v2_y           (cur_face.coords[7]),
		.v2_z           (cur_face.coords[8]),
		.last           (cur_face.last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.triangle_culled(triangle_culled),
		.mesh_outside   (mesh_outside),
		.end_of_mesh    (end_of_mesh)
	);

	always #6 clk = ~clk;

	// exact signed distance n.v + d, Q.18; zero counts as in front
	function automatic bit vertex_behind(logic [CFG_DATA_W-1:0] word, coord_t x, coord_t y,
		coord_t z);
		plane_t p;
		longint distance;
		p = plane_t'(word);
		distance = longint'($signed(p.nx)) * longint'($signed(x))
			+ longint'($signed(p.ny)) * longint'($signed(y))
			+ longint'($signed(p.nz)) * longint'($signed(z))
			+ (longint'($signed(p.d)) <<< D_ALIGN);
		return distance < 0;
	endfunction

	// plane counts above the lane count saturate
	function automatic int active_planes();
		return (int'(pred_plane_count) > MAX_PLANES) ? MAX_PLANES : int'(pred_plane_count);
	endfunction

	function automatic bit face_behind(logic [CFG_DATA_W-1:0] word, triangle_t f, int v);
		return vertex_behind(word, f.coords[3*v], f.coords[3*v+1], f.coords[3*v+2]);
	endfunction

	// verdict for one triangle; advances the mesh flag
	function automatic verdict_t classify_triangle(triangle_t f);
		verdict_t r;
		bit culled;
		culled = 1'b0;
		for (int i = 0; i < active_planes(); i++) begin
			if (face_behind(pred_planes[i], f, 0) && face_behind(pred_planes[i], f, 1) &&
				face_behind(pred_planes[i], f, 2))
				culled = 1'b1;
		end
		pred_all_culled = pred_all_culled && culled;
		r.culled  = culled;
		r.outside = f.last && pred_all_culled;
		r.eom     = f.last;
		if (f.last)
			pred_all_culled = 1'b1;
		return r;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] make_plane(int nx, int ny, int nz, int d);
		plane_t p;
		p.nx = nx[NRM_W-1:0];
		p.ny = ny[NRM_W-1:0];
		p.nz = nz[NRM_W-1:0];
		p.d  = d[DIST_W-1:0];
		return p;
	endfunction

	function automatic int normal_extreme();
		case ($urandom_range(0, 4))
			0: return -2048;
			1: return 2047;
			2: return 0;
			3: return -1;
			default: return 1024;
		endcase
	endfunction

	function automatic int offset_extreme();
		case ($urandom_range(0, 3))
			0: return -8388608;
			1: return 8388607;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_plane();
		int n [3];
		case ($urandom_range(0, 3))
			0: return CFG_DATA_W'({$urandom, $urandom});
			1: return make_plane(int'($urandom_range(0, 4095)) - 2048,
				int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
				int'($urandom_range(0, 65535)) - 32768);
			2: begin
				// axis-aligned plane with a moderate offset
				n = '{0, 0, 0};
				n[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 1024 : -1024;
				return make_plane(n[0], n[1], n[2], int'($urandom_range(0, 1 << 20)) - (1 << 19));
			end
			default: return make_plane(normal_extreme(), normal_extreme(), normal_extreme(),
				offset_extreme());
		endcase
	endfunction

	function automatic coord_t random_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return coord_t'($urandom);
			5, 6, 7: return coord_t'(int'($urandom_range(0, 32)) - 16);
			8: begin
				case ($urandom_range(0, 4))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return '0;
					3: return '1;
					default: return coord_t'(1);
				endcase
			end
			default: return coord_t'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
		endcase
	endfunction

	// random triangle; when a cull is wanted, pull each vertex behind one live plane
	function automatic triangle_t make_face(bit want_cull, bit lst);
		triangle_t f;
		int k;
		int tries;
		for (int j = 0; j < 9; j++)
			f.coords[j] = random_coord();
		if (want_cull && active_planes() > 0) begin
			k = $urandom_range(0, active_planes() - 1);
			for (int v = 0; v < 3; v++) begin
				tries = 0;
				while (!face_behind(pred_planes[k], f, v) && tries < 24) begin
					for (int a = 0; a < 3; a++)
						f.coords[3*v+a] = random_coord();
					tries++;
				end
			end
		end
		f.last = lst;
		return f;
	endfunction

	function automatic triangle_t uniform_face(coord_t x, coord_t y, coord_t z, bit lst);
		triangle_t f;
		for (int v = 0; v < 3; v++) begin
			f.coords[3*v]   = x;
			f.coords[3*v+1] = y;
			f.coords[3*v+2] = z;
		end
		f.last = lst;
		return f;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// one register write, mirrored into the prediction state
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx < NUM_PLANE_REGS)
			pred_planes[idx] = data;
		else if (idx == REG_PLANE_COUNT)
			pred_plane_count = data[CNT_W-1:0];
	endtask

	task automatic write_plane(int i, logic [CFG_DATA_W-1:0] word);
		cfg_write(CFG_IDX_W'(REG_PLANE_0 + i), word);
	endtask

	// count with junk in the unused upper bits
	task automatic write_plane_count(int n);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'({$urandom, $urandom});
		word[CNT_W-1:0] = n[CNT_W-1:0];
		cfg_write(REG_PLANE_COUNT, word);
	endtask

	// wait until every queued transaction has produced its verdict
	task automatic drain();
		int n;
		n = 0;
		while ((pending_faces.size() != 0 || in_valid || expected_verdicts.size() != 0) &&
			n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic randomise_config();
		int r;
		for (int i = 0; i < NUM_PLANE_REGS; i++)
			write_plane(i, random_plane());
		r = $urandom_range(0, 9);
		if (r == 0)
			write_plane_count(0);
		else if (r == 1)
			write_plane_count(7);
		else
			write_plane_count($urandom_range(1, MAX_PLANES));
		if ($urandom_range(0, 3) == 0)
			cfg_write(REG_NONE, CFG_DATA_W'({$urandom, $urandom}));
	endtask

	// meshes of one to five triangles, plus loose triangles with a random last mark
	task automatic queue_random_meshes(int n_items);
		int made;
		int kind;
		int len;
		made = 0;
		while (made < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				pending_faces.push_back(make_face($urandom_range(0, 1), $urandom_range(0, 1)));
				made++;
			end else begin
				len = $urandom_range(1, 5);
				for (int j = 0; j < len; j++)
					pending_faces.push_back(make_face((kind < 6) ? 1'b1 : 1'($urandom_range(0, 1)),
						j == len - 1));
				made += len;
			end
		end
	endtask

	// sender: present queued transactions, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_verdicts.push_back(classify_triangle(cur_face));
			if (!in_valid || in_ready) begin
				if (pending_faces.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_face <= pending_faces.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random back-pressure, or a long hold when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// hold the output off long enough to back the block up into its input
	initial begin
		wait (stall_wanted);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// check each verdict against the oldest prediction
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("verdict arrived with none expected");
			end else begin
				want = expected_verdicts.pop_front();
				if (triangle_culled !== want.culled || mesh_outside !== want.outside ||
					end_of_mesh !== want.eom)
					report_mismatch($sformatf(
						"culled %b/%b outside %b/%b end %b/%b (got/expected)",
						triangle_culled, want.culled, mesh_outside, want.outside,
						end_of_mesh, want.eom));
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		triangle_t f;
		for (int i = 0; i < NUM_PLANE_REGS; i++)
			pred_planes[i] = '0;
		pred_plane_count = PLANE_COUNT_RST;
		pred_all_culled  = 1'b1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// single plane x >= 0: zero distance, extremes and short meshes
		write_plane(0, make_plane(1024, 0, 0, 0));
		write_plane_count(1);
		pending_faces.push_back(uniform_face('0, '0, '0, 1'b0));
		pending_faces.push_back(uniform_face('1, COORD_MAX, COORD_MIN, 1'b0));
		f = uniform_face('1, '1, '1, 1'b1);
		f.coords[6] = '0;
		pending_faces.push_back(f);
		pending_faces.push_back(uniform_face(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
		pending_faces.push_back(uniform_face(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
		pending_faces.push_back(uniform_face('1, '0, '0, 1'b1));
		pending_faces.push_back(uniform_face(COORD_MIN, COORD_MAX, '0, 1'b0));
		pending_faces.push_back(uniform_face(coord_t'(-256), coord_t'(1), '1, 1'b0));
		pending_faces.push_back(uniform_face('1, COORD_MIN, COORD_MAX, 1'b1));
		f = uniform_face('1, '0, '0, 1'b1);
		f.coords[3] = COORD_MIN;
		f.coords[6] = coord_t'(1);
		pending_faces.push_back(f);
		drain();

		// extreme plane words, all six lanes, and a write to a missing register
		write_plane(0, make_plane(-2048, 2047, -2048, -8388608));
		write_plane(1, '1);
		write_plane(2, make_plane(2047, 2047, 2047, 8388607));
		write_plane(3, '0);
		write_plane(4, make_plane(0, 0, 0, 0));
		write_plane(5, make_plane(0, -1024, 0, -256));
		write_plane_count(MAX_PLANES);
		cfg_write(REG_NONE, '1);
		pending_faces.push_back(uniform_face(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
		pending_faces.push_back(uniform_face(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
		pending_faces.push_back(uniform_face('0, '0, '0, 1'b0));
		f = uniform_face(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
		f.coords[4] = COORD_MAX;
		f.coords[8] = COORD_MIN;
		pending_faces.push_back(f);
		pending_faces.push_back(uniform_face(COORD_MIN, '1, COORD_MAX, 1'b1));
		drain();

		// plane count above the lane count saturates
		write_plane_count(7);
		pending_faces.push_back(uniform_face(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
		pending_faces.push_back(uniform_face(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
		pending_faces.push_back(make_face(1'b1, 1'b1));
		drain();

		// no planes: nothing culled, mesh never outside
		write_plane_count(0);
		pending_faces.push_back(uniform_face(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
		pending_faces.push_back(uniform_face(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
		drain();

		// random meshes under changing settings and idling patterns
		for (int run = 0; run < RANDOM_RUNS; run++) begin
			if (run < RANDOM_RUNS / 3) begin
				send_idle_pct = 17;
				recv_idle_pct = 67;
			end else if (run < 2 * RANDOM_RUNS / 3) begin
				send_idle_pct = 67;
				recv_idle_pct = 17;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			randomise_config();
			queue_random_meshes(ITEMS_PER_RUN);
			if (run == 2 * RANDOM_RUNS / 3)
				stall_wanted = 1'b1;
			drain();
		end

		if (expected_verdicts.size() != 0)
			report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
